>>> rtl/core/mrfb_pkg.sv
// mrfb_pkg: shared types, constants and the CRC-16 byte update for the
// request frame builder. No dependencies.
package mrfb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FRAME_LEN   = 8;
  localparam int unsigned BODY_LEN    = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  FUNC_READ  = 8'h04;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;

  localparam logic [7:0]  ADDR_RESET  = 8'h11;
  localparam logic [15:0] START_RESET = 16'h0000;
  localparam logic [15:0] COUNT_RESET = 16'h0050;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_READ_START = 2'd1,
    CFG_READ_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Frame body as it sits in the queue: six bytes before the CRC.
  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [7:0]  func;
    logic [15:0] hi_word;
    logic [15:0] lo_word;
  } frame_body_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/modbus_request_frame_builder_unit.sv
// Modbus RTU request frame builder, top level.
// Input channel (in_valid/in_stall): one beat per request; in_cmd 0 builds a
// read-input-registers frame (function 0x04) from cfg registers, 1 builds a
// write-single-register frame (0x06) from in_register_number/value.
// Output channel (out_valid/out_stall): eight beats per request, in transmit
// order: address, function, four data bytes, CRC high, CRC low (out_last).
// Config port: cfg_we writes cfg_wdata to register cfg_index
// (0 device address, 1 read start, 2 read count); other indexes are ignored.
// The request body is registered in the queue, and each byte in the output
// register before it leaves. Throughput: one byte per cycle while out_stall is
// low; the output serializer with its byte-wise CRC update sets this rate.
// A queue of QDEPTH bodies lets requests be taken while a frame is sent.
// Reset (rst_n low, synchronous) empties queue and output register and
// restores the config reset values (0x11, 0x0000, 0x0050).
// A stall on the output holds the current byte; once the queue fills,
// in_stall rises.
// Depends on mrfb_pkg, mrfb_front, mrfb_queue, mrfb_back.
module modbus_request_frame_builder_unit
  import mrfb_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [15:0]           in_register_number,
  input  logic [15:0]           in_register_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_frame_byte,
  output logic                  out_last
);

  logic        q_push, q_full, q_pop, q_valid;
  frame_body_t q_wdata, q_rdata;

  mrfb_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_register_number (in_register_number),
    .in_register_value  (in_register_value),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_wdata            (q_wdata)
  );

  mrfb_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  mrfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule

>>> rtl/core/mrfb_front.sv
// mrfb_front: configuration registers and request intake; classifies each
// request and builds the frame body. Depends on mrfb_pkg.
module mrfb_front
  import mrfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [15:0]           in_register_number,
  input  logic [15:0]           in_register_value,
  input  logic                  q_full,
  output logic                  q_push,
  output frame_body_t           q_wdata
);

  logic [7:0]  dev_addr_r;
  logic [15:0] read_start_r;
  logic [15:0] read_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= ADDR_RESET;
      read_start_r <= START_RESET;
      read_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEV_ADDR:   dev_addr_r   <= cfg_wdata[7:0];
        CFG_READ_START: read_start_r <= cfg_wdata;
        CFG_READ_COUNT: read_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.dev_addr = dev_addr_r;
    if (cmd_t'(in_cmd) == CMD_WRITE) begin
      q_wdata.func    = FUNC_WRITE;
      q_wdata.hi_word = in_register_number;
      q_wdata.lo_word = in_register_value;
    end else begin
      q_wdata.func    = FUNC_READ;
      q_wdata.hi_word = read_start_r;
      q_wdata.lo_word = read_count_r;
    end
  end

endmodule

>>> rtl/core/mrfb_queue.sv
// mrfb_queue: small FIFO of frame bodies between front and back.
// Depends on mrfb_pkg.
module mrfb_queue
  import mrfb_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_body_t wdata,
  output logic        full,
  input  logic        pop,
  output logic        valid,
  output frame_body_t rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_body_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_FULL);
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/core/mrfb_back.sv
// mrfb_back: serializes one frame body per eight beats, folding each body
// byte into the CRC as it goes out, then sends CRC high and low. Uses mrfb_pkg.
module mrfb_back
  import mrfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  frame_body_t q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last
);

  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(BODY_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             advance;
  logic [7:0]       cur_byte;
  logic [15:0]      crc_base;

  // Output register is free when empty or being taken this cycle.
  assign advance = q_valid && (!valid_r || !out_stall);
  assign q_pop   = advance && (idx_r == IDX_LAST);

  always_comb begin
    unique case (idx_r)
      3'd0:    cur_byte = q_rdata.dev_addr;
      3'd1:    cur_byte = q_rdata.func;
      3'd2:    cur_byte = q_rdata.hi_word[15:8];
      3'd3:    cur_byte = q_rdata.hi_word[7:0];
      3'd4:    cur_byte = q_rdata.lo_word[15:8];
      3'd5:    cur_byte = q_rdata.lo_word[7:0];
      3'd6:    cur_byte = crc_r[15:8];
      default: cur_byte = crc_r[7:0];
    endcase
  end

  assign crc_base = (idx_r == '0) ? CRC_INIT : crc_r;

  always_comb begin
    crc_nxt = crc_r;
    idx_nxt = idx_r;
    if (advance) begin
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      if (idx_r < IDX_CRC_HI) begin
        crc_nxt = crc_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (advance) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (advance) begin
      byte_r <= cur_byte;
      last_r <= (idx_r == IDX_LAST);
    end
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_last       = last_r;

endmodule

>>> rtl/core/mrfb_checker.sv
// mrfb_checker: port-level checks of the frame builder output stream,
// bound to the top level. Depends on mrfb_pkg.
module mrfb_checker
  import mrfb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_last
);

  logic [2:0] beat_r;
  logic       out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (out_take) begin
      beat_r <= beat_r + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) && $stable(out_last))
    else $error("stalled output beat changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (beat_r == 3'd7)))
    else $error("last flag not on eighth beat of frame");

  a_func: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && beat_r == 3'd1 |->
      (out_frame_byte == FUNC_READ) || (out_frame_byte == FUNC_WRITE))
    else $error("bad function code in frame");

  // first cycle out of reset shows no beat
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind modbus_request_frame_builder_unit mrfb_checker u_mrfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_last       (out_last)
);

>>> test/tb_modbus_request_frame_builder_unit.sv
// Testbench for modbus_request_frame_builder_unit: read and write request
// frames checked byte by byte against a local frame and CRC-16 predictor.
// Depends on mrfb_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_modbus_request_frame_builder_unit;
  import mrfb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int IDLE_PCT = 28;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_cmd = 1'b0;
  logic [15:0]           in_register_number = '0;
  logic [15:0]           in_register_value = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            out_frame_byte;
  logic                  out_last;

  // expected frame bytes, oldest first
  frame_beat_t pending_beats[$];

  // local copy of the configuration registers
  logic [7:0]  shadow_addr;
  logic [15:0] shadow_start;
  logic [15:0] shadow_count;

  int mismatch_count = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold_len = 0;
  int rx_held = 0;

  modbus_request_frame_builder_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_register_number (in_register_number),
    .in_register_value  (in_register_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_byte     (out_frame_byte),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  // Serial LSB-first form of the Modbus CRC; body[47:40] is the first byte.
  function automatic logic [15:0] modbus_crc(input logic [47:0] body);
    logic [15:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int b = 0; b < 8; b++) begin
        fb = crc[0] ^ body[40 - 8 * i + b];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  function automatic void predict_frame(input cmd_t cmd, input logic [15:0] num,
                                        input logic [15:0] val);
    logic [15:0] hi_word;
    logic [15:0] lo_word;
    logic [7:0]  func;
    logic [47:0] body;
    logic [63:0] frame;
    frame_beat_t beat;
    hi_word = (cmd == CMD_WRITE) ? num : shadow_start;
    lo_word = (cmd == CMD_WRITE) ? val : shadow_count;
    func = (cmd == CMD_WRITE) ? FUNC_WRITE : FUNC_READ;
    body = {shadow_addr, func, hi_word, lo_word};
    // CRC goes out high byte first
    frame = {body, modbus_crc(body)};
    for (int i = 0; i < 8; i++) begin
      beat.data = frame[63 - 8 * i -: 8];
      beat.last = (i == 7);
      pending_beats.push_back(beat);
    end
  endfunction

  function automatic logic [15:0] rand_word();
    int k;
    k = $urandom_range(15);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << k;
      3: return ~(16'h0001 << k);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic send_request(input cmd_t cmd, input logic [15:0] num,
                              input logic [15:0] val);
    if (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_register_number <= num;
    in_register_value <= val;
    do @(posedge clk); while (in_stall);
    predict_frame(cmd, num, val);
  endtask

  task automatic send_random_request();
    send_request(cmd_t'($urandom_range(1)), rand_word(), rand_word());
  endtask

  // drops valid and waits until every predicted byte has been seen
  task automatic wait_frames_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEV_ADDR:   shadow_addr = data[7:0];
      CFG_READ_START: shadow_start = data;
      CFG_READ_COUNT: shadow_count = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_request(CMD_READ, 16'h1234, 16'h5678);
    send_request(CMD_WRITE, 16'h0001, 16'h0003);
    wait_frames_done();
  endtask

  task automatic test_field_extremes();
    send_request(CMD_WRITE, 16'h0000, 16'h0000);
    send_request(CMD_WRITE, 16'hFFFF, 16'hFFFF);
    send_request(CMD_WRITE, 16'h00FF, 16'hFF00);
    send_request(CMD_WRITE, 16'hAAAA, 16'h5555);
    send_request(CMD_WRITE, 16'h5555, 16'hAAAA);
    // read ignores both fields
    send_request(CMD_READ, 16'hFFFF, 16'hFFFF);
    wait_frames_done();
  endtask

  task automatic test_config_extremes();
    // third address has upper bits set that the register drops
    logic [15:0] addr_set [3] = '{16'h0000, 16'h00FF, 16'hAB5A};
    logic [15:0] start_set [3] = '{16'h0000, 16'hFFFF, 16'h8001};
    logic [15:0] count_set [3] = '{16'h0000, 16'hFFFF, 16'h007D};
    for (int s = 0; s < 3; s++) begin
      write_cfg(CFG_DEV_ADDR, addr_set[s]);
      write_cfg(CFG_READ_START, start_set[s]);
      write_cfg(CFG_READ_COUNT, count_set[s]);
      send_request(CMD_READ, 16'h0000, 16'h0000);
      send_random_request();
      wait_frames_done();
    end
    // unmapped index must leave all registers alone
    write_cfg(CFG_IDX_SPARE, 16'hFFFF);
    send_request(CMD_READ, 16'hFFFF, 16'h0000);
    wait_frames_done();
  endtask

  task automatic test_output_holdoff();
    tx_quiet = 1'b1;
    rx_hold_len <= RX_HOLD_CYCLES;
    for (int i = 0; i < 10; i++) begin
      send_random_request();
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (rx_held < rx_hold_len);
    rx_hold_len <= 0;
    tx_quiet = 1'b0;
    wait_frames_done();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 6; i++) begin
      send_random_request();
    end
    wait_frames_done();
    for (int i = 0; i < 6; i++) begin
      send_random_request();
    end
    wait_frames_done();
  endtask

  task automatic test_random_traffic();
    int phase_items [3] = '{80, 50, 93};
    bit phase_quiet [3] = '{1'b0, 1'b1, 1'b0};
    for (int p = 0; p < 3; p++) begin
      write_cfg(CFG_DEV_ADDR, rand_word());
      write_cfg(CFG_READ_START, rand_word());
      write_cfg(CFG_READ_COUNT, rand_word());
      tx_quiet = phase_quiet[p];
      rx_quiet <= phase_quiet[p];
      for (int i = 0; i < phase_items[p]; i++) begin
        send_random_request();
      end
      wait_frames_done();
    end
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  // receiver: random stalls, quiet stretches, and a counted long hold-off
  always @(posedge clk) begin
    if (rx_hold_len != 0 && rx_held < rx_hold_len) begin
      out_stall <= 1'b1;
      rx_held <= rx_held + 1;
    end else begin
      if (rx_hold_len == 0) begin
        rx_held <= 0;
      end
      out_stall <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_beats
    frame_beat_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("byte with no frame pending", 16'(out_frame_byte), 16'h0000);
      end else begin
        want = pending_beats.pop_front();
        if (out_frame_byte !== want.data) begin
          report_mismatch("frame_byte", 16'(out_frame_byte), 16'(want.data));
        end
        if (out_last !== want.last) begin
          report_mismatch("last", 16'(out_last), 16'(want.last));
        end
      end
    end
  end

  initial begin
    shadow_addr = ADDR_RESET;
    shadow_start = START_RESET;
    shadow_count = COUNT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_config_extremes();
    test_output_holdoff();
    test_sender_pause();
    test_random_traffic();
    wait_frames_done();
    // catch any stray beat after the last frame
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrfb_pkg.sv
rtl/core/mrfb_front.sv
rtl/core/mrfb_queue.sv
rtl/core/mrfb_back.sv
rtl/core/modbus_request_frame_builder_unit.sv
rtl/core/mrfb_checker.sv
test/tb_modbus_request_frame_builder_unit.sv
